@@ rtl/core/gre_dcp_pkg.sv @@
package gre_dcp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LinkW     = 7;
  localparam int unsigned PosW      = 17;
  localparam int unsigned LenW      = 17;
  localparam int unsigned TotLenW   = 16;
  localparam int unsigned HdrWordsW = 4;
  localparam int unsigned OffsW     = 8;   // link + ip header + gre + options stay below 256
  localparam int unsigned RemW      = 18;  // signed room left for the inner packet

  localparam logic [LinkW-1:0] LinkHeaderReset = 7'd14;
  localparam logic [OffsW-1:0] OptWordBytes    = 8'd4;
  localparam logic [OffsW-1:0] GreHeaderBytes  = 8'd4;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_byte_valid;
    logic             out_last;
    logic [LenW-1:0]  frame_length;
    logic             truncated;
    logic             malformed;
  } out_t;

  // input register contents
  typedef struct packed {
    logic valid;
    in_t  data;
  } item_t;

  // result handed to the output register
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  // option bytes from the top nibble of the gre flag word
  function automatic logic [OffsW-1:0] option_bytes(input logic [3:0] flags_hi);
    logic [OffsW-1:0] n;
    n = '0;
    if (flags_hi[3] | flags_hi[2]) n = n + OptWordBytes;
    if (flags_hi[1])               n = n + OptWordBytes;
    if (flags_hi[0])               n = n + OptWordBytes;
    return n;
  endfunction

endpackage

@@ rtl/core/gre_dcp_in_reg.sv @@
module gre_dcp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gre_dcp_pkg::in_t   in_data_i,
  input  logic               advance_i,
  output gre_dcp_pkg::item_t item_o
);
  import gre_dcp_pkg::*;

  logic valid_q;
  in_t  data_q;

  // hold off only while a request sits here and the next stage cannot move
  assign in_stall_o = valid_q & ~advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

@@ rtl/core/gre_dcp_parser.sv @@
module gre_dcp_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [gre_dcp_pkg::LinkW-1:0]   link_bytes_i,
  input  gre_dcp_pkg::item_t              item_i,
  input  logic                            advance_i,
  output gre_dcp_pkg::res_t               res_o
);
  import gre_dcp_pkg::*;

  logic [PosW-1:0]      pos_q, pos_d;
  logic [HdrWordsW-1:0] hw_q, hw_d;
  logic [TotLenW-1:0]   tl_q, tl_d;
  logic [3:0]           flags_q, flags_d;
  logic [OffsW-1:0]     ist_q, ist_d;
  logic [LenW-1:0]      be_q, be_d;
  logic                 fin_q, fin_d;

  logic [PosW-1:0]  p, link_p, gre_p;
  logic [ByteW-1:0] b;
  logic             last;
  logic [OffsW-1:0] gre_off;
  logic [RemW-1:0]  rem;
  logic             rem_neg, rem_pos;
  logic             done_neg;
  logic [LenW-1:0]  done, be_inc;
  logic             step;

  assign step   = item_i.valid & advance_i;
  assign p      = pos_q;
  assign b      = item_i.data.in_byte;
  assign last   = item_i.data.in_last;
  assign link_p = {{(PosW-LinkW){1'b0}}, link_bytes_i};

  // header field capture, in wire order
  always_comb begin
    hw_d = (p == link_p) ? b[3:0] : hw_q;
    tl_d = tl_q;
    if (p == link_p + 17'd2) tl_d[15:8] = b;
    if (p == link_p + 17'd3) tl_d[7:0]  = b;
    gre_off = {1'b0, link_bytes_i} + {2'b00, hw_d, 2'b00};
    gre_p   = {{(PosW-OffsW){1'b0}}, gre_off};
    flags_d = (p == gre_p) ? b[7:4] : flags_q;
    ist_d   = (p == gre_p + 17'd1)
              ? gre_off + GreHeaderBytes + option_bytes(flags_d) : ist_q;
  end

  // room left for the inner packet and progress through it
  always_comb begin
    rem      = {2'b00, tl_d} - {{(RemW-OffsW){1'b0}}, ist_d}
               + {{(RemW-LinkW){1'b0}}, link_bytes_i};
    rem_neg  = rem[RemW-1];
    rem_pos  = ~rem_neg & (rem != '0);
    done_neg = be_q < {{(LenW-LinkW){1'b0}}, link_bytes_i};
    done     = be_q - {{(LenW-LinkW){1'b0}}, link_bytes_i};
    be_inc   = be_q + 17'd1;
  end

  always_comb begin
    res_o      = '0;
    pos_d      = (pos_q != {PosW{1'b1}}) ? pos_q + 17'd1 : pos_q;
    be_d       = be_q;
    fin_d      = fin_q;
    if (fin_q) begin
      pos_d = pos_q;
    end else if (p < link_p) begin
      // link header copied through
      be_d                    = be_inc;
      res_o.valid             = 1'b1;
      res_o.data.out_byte     = b;
      res_o.data.out_byte_valid = 1'b1;
      res_o.data.out_last     = last;
      res_o.data.frame_length = last ? be_inc : '0;
      res_o.data.truncated    = last;
    end else if ((p > gre_p + 17'd1) && (p >= {{(PosW-OffsW){1'b0}}, ist_d})) begin
      if ((p == {{(PosW-OffsW){1'b0}}, ist_d}) && !rem_pos) begin
        // nothing inside: status only
        res_o.valid             = 1'b1;
        res_o.data.out_last     = 1'b1;
        res_o.data.frame_length = be_q;
        res_o.data.malformed    = rem_neg;
        fin_d                   = 1'b1;
      end else if (rem_pos && !done_neg && ({1'b0, done} < rem)) begin
        be_d                      = be_inc;
        res_o.valid               = 1'b1;
        res_o.data.out_byte       = b;
        res_o.data.out_byte_valid = 1'b1;
        if ({1'b0, done} + 18'd1 == rem) begin
          res_o.data.out_last     = 1'b1;
          res_o.data.frame_length = be_inc;
          fin_d                   = 1'b1;
        end else if (last) begin
          res_o.data.out_last     = 1'b1;
          res_o.data.frame_length = be_inc;
          res_o.data.truncated    = 1'b1;
        end
      end else begin
        fin_d = 1'b1;
      end
    end else if (last) begin
      // capture ended inside the headers
      res_o.valid             = 1'b1;
      res_o.data.out_last     = 1'b1;
      res_o.data.frame_length = be_q;
      res_o.data.truncated    = 1'b1;
    end
    if (!step) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hw_q    <= '0;
      tl_q    <= '0;
      flags_q <= '0;
      ist_q   <= '0;
      be_q    <= '0;
      fin_q   <= 1'b0;
    end else if (step) begin
      if (last) begin
        pos_q   <= '0;
        hw_q    <= '0;
        tl_q    <= '0;
        flags_q <= '0;
        ist_q   <= '0;
        be_q    <= '0;
        fin_q   <= 1'b0;
      end else if (!fin_q) begin
        pos_q   <= pos_d;
        hw_q    <= hw_d;
        tl_q    <= tl_d;
        flags_q <= flags_d;
        ist_q   <= ist_d;
        be_q    <= be_d;
        fin_q   <= fin_d;
      end
    end
  end

endmodule

@@ rtl/core/gre_dcp_out_reg.sv @@
module gre_dcp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gre_dcp_pkg::res_t res_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gre_dcp_pkg::out_t out_data_o
);
  import gre_dcp_pkg::*;

  logic valid_q;
  out_t data_q;

  // room when empty or when the held request leaves this cycle
  assign advance_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/core/gre_decapsulator.sv @@
// channel   direction  handshake                payload
// --------  ---------  -----------------------  -----------------------------------
// in        sink       in_valid_i / in_stall_o  in_data_i  : frame byte, last flag
// out       source     out_valid_o/ out_stall_i out_data_o : byte, flags, length
// cfg       sink       cfg_we_i                 cfg_wdata_i: link header bytes
//
// one request per cycle sustained while the output is not stalled; each request goes
// through the input register, then the single-pass parse into the output register
// reset clears all frame state, empties both registers and sets the link
// header length to 14
// output stall backs up through the output and input registers; an input
// request is still taken into an empty input register while a finished result waits to be collected
module gre_decapsulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gre_dcp_pkg::in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gre_dcp_pkg::out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gre_dcp_pkg::LinkW-1:0] cfg_wdata_i
);
  import gre_dcp_pkg::*;

  // link header length register
  logic [LinkW-1:0] link_bytes_q;

  item_t item;
  res_t  res;
  logic  advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_bytes_q <= LinkHeaderReset;
    end else if (cfg_we_i) begin
      link_bytes_q <= cfg_wdata_i;
    end
  end

  // input register
  gre_dcp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .item_o     (item)
  );

  // header tracking and the per-byte decision
  gre_dcp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .link_bytes_i (link_bytes_q),
    .item_i       (item),
    .advance_i    (advance),
    .res_o        (res)
  );

  // result register towards the consumer
  gre_dcp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import gre_dcp_pkg::*;

  localparam int unsigned PosMax    = 'h1FFFF;
  localparam int unsigned LenMask   = 'h1FFFF;
  localparam int unsigned IdleLimit = 2000;   // cycles with no handshake at all
  localparam int unsigned ShowLimit = 30;     // error lines printed, the rest only counted
  localparam int unsigned SettleCyc = 6;      // pipeline depth plus margin before a config write

  // one row of the directed table: either a config write or a frame byte
  typedef struct {
    bit         is_cfg;
    logic [6:0] cfg_val;
    logic [7:0] b;
    bit         last;
    bit         typed;   // expected result written into the row
    out_t       exp;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_t                 in_data;
  logic                out_valid;
  logic                out_stall;
  out_t                out_data;
  logic                cfg_we;
  logic [LinkW-1:0]    cfg_wdata;

  gre_decapsulator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // decapsulator state as the predictor sees it
  int unsigned link_hdr = LinkHeaderReset;
  int unsigned pos;
  int unsigned hdr_words;
  int unsigned total_len;
  int unsigned gre_flags;
  int unsigned inner_pos;
  int unsigned emitted;
  bit          frame_done;

  out_t        results_due[$];     // expected results, oldest first
  dir_row_t    dir_rows[$];

  // directed row fields, set by the driver alongside the request
  bit          row_typed;
  out_t        row_exp;

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned n_in, n_out, n_frames, n_settings, n_status, n_trunc, n_bad;

  task automatic report(input string msg);
    if (errors < ShowLimit) $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [16:0] got,
                             input logic [16:0] want);
    if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  function automatic void restart_frame();
    pos        = 0;
    hdr_words  = 0;
    total_len  = 0;
    gre_flags  = 0;
    inner_pos  = 0;
    emitted    = 0;
    frame_done = 1'b0;
  endfunction

  function automatic out_t mk(input logic [7:0] b, input bit v, input bit l,
                              input int unsigned len, input bit t, input bit m);
    out_t r;
    r.out_byte       = b;
    r.out_byte_valid = v;
    r.out_last       = l;
    r.frame_length   = len[LenW-1:0];
    r.truncated      = t;
    r.malformed      = m;
    return r;
  endfunction

  // one byte through the decapsulator; returns 1 when it yields a result
  function automatic bit decap_byte(input in_t it, output out_t r);
    int unsigned b, p, lnk, g, opt, done;
    int          room;
    bit          last, hit;
    b    = it.in_byte;
    last = it.in_last;
    p    = pos;
    lnk  = link_hdr;
    hit  = 1'b0;
    r    = '0;
    // past the computed length: drop, and only the end of capture matters
    if (frame_done) begin
      if (last) restart_frame();
      return 1'b0;
    end
    if (p == lnk)      hdr_words = b & 'hF;
    if (p == lnk + 2)  total_len = (total_len & 'hFF) | (b << 8);
    if (p == lnk + 3)  total_len = (total_len & 'hFF00) | b;
    g = lnk + hdr_words * 4;
    if (p == g)        gre_flags = (gre_flags & 'hFF) | (b << 8);
    if (p == g + 1) begin
      gre_flags = (gre_flags & 'hFF00) | b;
      opt = 0;
      if (gre_flags & 'hC000) opt += OptWordBytes;
      if (gre_flags & 'h2000) opt += OptWordBytes;
      if (gre_flags & 'h1000) opt += OptWordBytes;
      inner_pos = (g + GreHeaderBytes + opt) & LenMask;
    end
    if (p < lnk) begin
      // link header copied through
      emitted = (emitted + 1) & LenMask;
      r   = mk(b[7:0], 1'b1, last, last ? emitted : 0, last, 1'b0);
      hit = 1'b1;
    end else if (p > g + 1 && p >= inner_pos) begin
      room = int'(total_len) - int'(inner_pos - lnk);
      done = emitted - lnk;
      if (p == inner_pos && room <= 0) begin
        // nothing left for the inner packet, or less than nothing
        r          = mk(8'h00, 1'b0, 1'b1, emitted, 1'b0, room < 0);
        frame_done = 1'b1;
        hit        = 1'b1;
      end else if (room > 0 && done < int'(room)) begin
        emitted = (emitted + 1) & LenMask;
        if (done + 1 == int'(room)) begin
          r          = mk(b[7:0], 1'b1, 1'b1, emitted, 1'b0, 1'b0);
          frame_done = 1'b1;
        end else if (last) begin
          r = mk(b[7:0], 1'b1, 1'b1, emitted, 1'b1, 1'b0);
        end else begin
          r = mk(b[7:0], 1'b1, 1'b0, 0, 1'b0, 1'b0);
        end
        hit = 1'b1;
      end else begin
        frame_done = 1'b1;
      end
    end else if (last) begin
      // capture ended inside the headers
      r   = mk(8'h00, 1'b0, 1'b1, emitted, 1'b1, 1'b0);
      hit = 1'b1;
    end
    if (pos < PosMax) pos++;
    if (last) restart_frame();
    return hit;
  endfunction

  // monitor: predictor, scoreboard and watchdog, all on the rising edge
  always @(posedge clk) begin
    out_t pred;
    out_t want;
    bit   any;
    if (rst_n) begin
      any = 1'b0;
      if (out_valid && !out_stall) begin
        any = 1'b1;
        n_out++;
        if (results_due.size() == 0) begin
          report($sformatf("result %0h with nothing expected", out_data));
        end else begin
          want = results_due.pop_front();
          check_field("out_byte",       17'(out_data.out_byte),       17'(want.out_byte));
          check_field("out_byte_valid", 17'(out_data.out_byte_valid), 17'(want.out_byte_valid));
          check_field("out_last",       17'(out_data.out_last),       17'(want.out_last));
          check_field("frame_length",   out_data.frame_length,        want.frame_length);
          check_field("truncated",      17'(out_data.truncated),      17'(want.truncated));
          check_field("malformed",      17'(out_data.malformed),      17'(want.malformed));
        end
      end
      if (in_valid && !in_stall) begin
        any = 1'b1;
        n_in++;
        if (decap_byte(in_data, pred) || row_typed) begin
          if (row_typed) pred = row_exp;
          results_due.push_back(pred);
          if (pred.out_last && !pred.out_byte_valid) n_status++;
          if (pred.truncated) n_trunc++;
          if (pred.malformed) n_bad++;
        end
      end
      if (cfg_we) begin
        any      = 1'b1;
        link_hdr = cfg_wdata;
      end
      if (any) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IdleLimit) begin
          $display("gre_decapsulator: mismatch");
          $finish;
        end
      end
    end
  end

  // receiver stall: a fresh 16-bit pattern each window, some windows clear
  logic [15:0] stall_pat;
  logic [3:0]  stall_idx = '0;
  always @(negedge clk) begin
    if (stall_idx == 4'd0) begin
      case ($urandom_range(0, 2))
        0:       stall_pat = '0;
        1:       stall_pat = 16'($urandom & $urandom);
        default: stall_pat = 16'($urandom);
      endcase
    end
    out_stall <= stall_pat[stall_idx];
    stall_idx <= stall_idx + 4'd1;
  end

  // present one request; called and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input bit last, input bit typed,
                           input out_t exp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid      <= 1'b1;
    in_data       <= '{in_byte: b, in_last: last};
    row_typed      = typed;
    row_exp        = exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // link header length is only changed once the pipeline has drained
  task automatic set_link(input logic [6:0] v);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SettleCyc) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  task automatic dir_byte(input logic [7:0] b, input bit last);
    dir_rows.push_back('{is_cfg: 1'b0, cfg_val: '0, b: b, last: last,
                         typed: 1'b0, exp: '0});
  endtask

  task automatic dir_typed(input logic [7:0] b, input bit last, input out_t exp);
    dir_rows.push_back('{is_cfg: 1'b0, cfg_val: '0, b: b, last: last,
                         typed: 1'b1, exp: exp});
  endtask

  task automatic dir_cfg(input logic [6:0] v);
    dir_rows.push_back('{is_cfg: 1'b1, cfg_val: v, b: '0, last: 1'b0,
                         typed: 1'b0, exp: '0});
  endtask

  // random frame: mostly a well-formed encapsulation with random content,
  // sometimes pure noise, a bad total length or a cut-short capture
  task automatic send_frame(input int unsigned lnk);
    logic [7:0]  frm [256];
    int unsigned hw, olen, inner, n, g, tot;
    logic [3:0]  fl;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) frm[i] = 8'($urandom);
    end else begin
      hw    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      fl    = 4'($urandom);
      olen  = 0;
      if (fl[3] | fl[2]) olen += OptWordBytes;
      if (fl[1])         olen += OptWordBytes;
      if (fl[0])         olen += OptWordBytes;
      inner = $urandom_range(0, 12);
      tot   = hw * 4 + GreHeaderBytes + olen + inner;
      case ($urandom_range(0, 7))
        0:       tot = $urandom_range(0, tot);
        1:       tot = $urandom_range(0, 65535);
        default: ;
      endcase
      n = lnk + hw * 4 + GreHeaderBytes + olen + inner + $urandom_range(0, 4);
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) frm[i] = 8'($urandom);
      g = lnk + hw * 4;
      // header fields; with a zero-word ip header the flag nibble shares a byte
      if (lnk < n)     frm[lnk]     = {frm[lnk][7:4], hw[3:0]};
      if (lnk + 2 < n) frm[lnk + 2] = tot[15:8];
      if (lnk + 3 < n) frm[lnk + 3] = tot[7:0];
      if (g < n)       frm[g]       = {fl, frm[g][3:0]};
    end
    for (int i = 0; i < n; i++) push_byte(frm[i], i == n - 1, 1'b0, '0);
    n_frames++;
  endtask

  initial begin
    logic [6:0] settings [6];
    int unsigned start;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    row_typed = 1'b0;
    row_exp   = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // link header of 14 after reset: a lone byte is a cut-short link header
    dir_typed(8'hFF, 1'b1, mk(8'hFF, 1'b1, 1'b1, 1, 1'b1, 1'b0));
    dir_typed(8'h00, 1'b1, mk(8'h00, 1'b1, 1'b1, 1, 1'b1, 1'b0));
    dir_cfg(7'd0);
    // capture ends inside the gre header
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h00, 1'b0);
    dir_typed(8'h00, 1'b1, mk(8'h00, 1'b0, 1'b1, 0, 1'b1, 1'b0));
    // total length exactly covers the headers: empty inner packet
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h04, 1'b0);
    dir_typed(8'hAA, 1'b1, mk(8'h00, 1'b0, 1'b1, 0, 1'b0, 1'b0));
    // total length below the headers
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h02, 1'b0);
    dir_typed(8'h5A, 1'b1, mk(8'h00, 1'b0, 1'b1, 0, 1'b0, 1'b1));
    // key option, two inner bytes
    dir_byte(8'h20, 1'b0);
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h00, 1'b0);
    dir_byte(8'h0A, 1'b0);
    dir_byte(8'h11, 1'b0);
    dir_byte(8'h22, 1'b0);
    dir_byte(8'h33, 1'b0);
    dir_byte(8'h44, 1'b0);
    dir_byte(8'hFF, 1'b0);
    dir_byte(8'h00, 1'b1);
    // widest link header the register holds
    dir_cfg(7'd127);
    dir_typed(8'h80, 1'b1, mk(8'h80, 1'b1, 1'b1, 1, 1'b1, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_link(dir_rows[i].cfg_val);
      else push_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp);
    end
    row_typed = 1'b0;

    settings = '{7'd14, 7'd0, 7'd1, 7'd3, 7'd64, 7'($urandom_range(0, 127))};
    foreach (settings[k]) begin
      set_link(settings[k]);
      start = n_in;
      while (n_in - start < 30) send_frame(settings[k]);
    end
    set_link(7'd127);
    send_frame(127);

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (results_due.size() != 0) report("expected results left over");

    $display("covered %0d requests in %0d frames over %0d link header settings",
             n_in, n_frames, n_settings);
    $display("%0d results, %0d status-only, %0d truncated, %0d malformed",
             n_out, n_status, n_trunc, n_bad);
    if (errors == 0) begin
      $display("gre_decapsulator: match");
    end else begin
      $display("gre_decapsulator: mismatch");
    end
    $finish;
  end

endmodule
